[rtl/core/rac_pkg.sv]
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types for the rational add and compare unit.
// ----------------------------------------------------------------------------
package rac_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_GSH,
		ST_DIV,
		ST_DONE
	} rac_state_t;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_LT  = 1'b1;

endpackage

[rtl/core/rational_add_compare_unit.sv]
// ----------------------------------------------------------------------------
// rational_add_compare_unit
// Adds two signed fractions and reduces the sum, or compares them.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry opcode and the two fractions.
// Output channel: out_valid / out_stall carry result_num, result_den,
// less_flag and error_flag; every input transfer gives one output transfer.
// One item is worked on at a time; in_stall is high while it is in flight.
// Steps:
//   shift-add multiply (three products side by side), then the sum is
//   formed, then a binary gcd of one step per cycle, a shift per common
//   factor of two to rebuild the divisor, and restoring division that
//   divides numerator and denominator in parallel. The result then goes
//   into the output register. Compare, zero numerator and zero
//   denominator skip gcd and division.
// The output register frees the core: a finished result waits there while
// the next item is accepted. If the output is still stalled when the next
// result finishes, the core holds it and keeps in_stall high.
// Reset clears the state machine and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module rational_add_compare_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [OPERAND_WIDTH-1:0] first_num,
	input  logic signed [OPERAND_WIDTH-1:0] first_den,
	input  logic signed [OPERAND_WIDTH-1:0] second_num,
	input  logic signed [OPERAND_WIDTH-1:0] second_den,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [32:0]              result_num,
	output logic signed [31:0]              result_den,
	output logic                            less_flag,
	output logic                            error_flag
);
	import rac_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int M  = 2 * W + 1;
	localparam int CW = $clog2(M + 1);
	localparam int XW = (M > 33) ? M + 1 : 34;

	rac_state_t state_q, state_d;

	logic          op_q, neg_n1_q, neg_d1_q, neg_n2_q, neg_d2_q;
	logic [PW-1:0] a_n1_q, a_n2_q, a_d1_q;
	logic [W-1:0]  b_d2_q, b_d1_q;
	logic [PW-1:0] acc1_q, acc2_q, acc3_q;
	logic [CW-1:0] cnt_q;
	logic [M-1:0]  nm_q, dm_q, ga_q, gb_q, rn_q, rd_q;
	logic          num_neg_q, den_neg_q, less_q, err_q;
	logic [CW-1:0] k_q;

	logic          accept, out_free;
	logic signed [M-1:0] p1, p2, sum;
	logic [M-1:0]  sum_mag;
	logic          sum_done_early;
	logic          gcd_zero;
	logic [M:0]    tn, td;
	logic          gn, gd;
	logic [XW-1:0] num_ext, den_ext;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// signed products from magnitudes and signs
	always_comb begin
		p1  = neg_n1_q ^ neg_d2_q ? -$signed({1'b0, acc1_q}) : $signed({1'b0, acc1_q});
		p2  = neg_n2_q ^ neg_d1_q ? -$signed({1'b0, acc2_q}) : $signed({1'b0, acc2_q});
		sum = p1 + p2;
		sum_mag = sum[M-1] ? (~sum + 1'b1) : sum;
		sum_done_early = (op_q == OP_LT) || (acc3_q == '0) || (sum == '0);
		gcd_zero = (ga_q == '0) || (gb_q == '0);
	end

	// one restoring division step for numerator and denominator
	always_comb begin
		tn = {rn_q, nm_q[M-1]};
		td = {rd_q, dm_q[M-1]};
		gn = (tn >= {1'b0, ga_q});
		gd = (td >= {1'b0, ga_q});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_MUL;
			ST_MUL:  if (cnt_q == CW'(W - 1)) state_d = ST_SUM;
			ST_SUM:  state_d = sum_done_early ? ST_DONE : ST_GCD;
			ST_GCD:  if (gcd_zero) state_d = ST_GSH;
			ST_GSH:  if (k_q == '0) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CW'(M - 1)) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= opcode;
					neg_n1_q <= first_num[W-1];
					neg_d1_q <= first_den[W-1];
					neg_n2_q <= second_num[W-1];
					neg_d2_q <= second_den[W-1];
					a_n1_q   <= {{W{1'b0}}, mag_w(first_num)};
					a_n2_q   <= {{W{1'b0}}, mag_w(second_num)};
					a_d1_q   <= {{W{1'b0}}, mag_w(first_den)};
					b_d2_q   <= mag_w(second_den);
					b_d1_q   <= mag_w(first_den);
					acc1_q   <= '0;
					acc2_q   <= '0;
					acc3_q   <= '0;
					cnt_q    <= '0;
				end
			end
			ST_MUL: begin
				if (b_d2_q[0]) acc1_q <= acc1_q + a_n1_q;
				if (b_d1_q[0]) acc2_q <= acc2_q + a_n2_q;
				if (b_d2_q[0]) acc3_q <= acc3_q + a_d1_q;
				a_n1_q <= a_n1_q << 1;
				a_n2_q <= a_n2_q << 1;
				a_d1_q <= a_d1_q << 1;
				b_d2_q <= b_d2_q >> 1;
				b_d1_q <= b_d1_q >> 1;
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_SUM: begin
				less_q    <= (op_q == OP_LT) && (p1 < p2);
				err_q     <= (op_q == OP_ADD) && (acc3_q == '0);
				num_neg_q <= sum[M-1];
				den_neg_q <= (neg_d1_q ^ neg_d2_q) && (acc3_q != '0);
				nm_q      <= (op_q == OP_LT) ? '0 : sum_mag;
				dm_q      <= (op_q == OP_LT) ? '0 : {1'b0, acc3_q};
				ga_q      <= sum_mag;
				gb_q      <= {1'b0, acc3_q};
				k_q       <= '0;
			end
			ST_GCD: begin
				if (ga_q == '0) begin
					ga_q <= gb_q;
				end else if (gb_q == '0) begin
					ga_q <= ga_q;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
				rn_q  <= '0;
				rd_q  <= '0;
				cnt_q <= '0;
			end
			ST_GSH: begin
				// restore the common factors of two
				if (k_q != '0) begin
					ga_q <= ga_q << 1;
					k_q  <= k_q - 1'b1;
				end
			end
			ST_DIV: begin
				rn_q  <= gn ? M'(tn - {1'b0, ga_q}) : tn[M-1:0];
				rd_q  <= gd ? M'(td - {1'b0, ga_q}) : td[M-1:0];
				nm_q  <= {nm_q[M-2:0], gn};
				dm_q  <= {dm_q[M-2:0], gd};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		num_ext = {{(XW-M){1'b0}}, nm_q};
		den_ext = {{(XW-M){1'b0}}, dm_q};
		if (num_neg_q) num_ext = ~num_ext + 1'b1;
		if (den_neg_q) den_ext = ~den_ext + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_num <= num_ext[32:0];
			result_den <= den_ext[31:0];
			less_flag  <= less_q;
			error_flag <= err_q;
		end
	end

	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MUL)
		else $error("accepted item did not start the multiply");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GSH || state_q == ST_DIV) |-> ga_q != '0)
		else $error("zero divisor in reduction");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(less_flag && error_flag))
		else $error("less and error both set");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid && out_stall) |=> state_q == ST_DONE)
		else $error("result left core while output stalled");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rational add and compare unit: directed corners, random
// fraction pairs and a long output hold, each result checked against an
// in-bench model of the cross-product sum, reduction and compare.
// ----------------------------------------------------------------------------
module tb_top;
	import rac_pkg::*;

	localparam int W = 16;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [32:0] num;
		logic signed [31:0] den;
		logic               less;
		logic               err;
	} frac_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic signed [W-1:0] first_num;
	logic signed [W-1:0] first_den;
	logic signed [W-1:0] second_num;
	logic signed [W-1:0] second_den;
	logic                out_valid;
	logic                out_stall;
	logic signed [32:0]  result_num;
	logic signed [31:0]  result_den;
	logic                less_flag;
	logic                error_flag;

	frac_result_t pending_results[$];
	int errors = 0;
	int sent_cnt = 0;
	int got_cnt = 0;
	int err_seen = 0;
	int cycles = 0;
	int burst_left = 0;
	bit sender_idle_en = 1;
	bit rx_stall_free = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int stall_pct = 30;

	rational_add_compare_unit #(.OPERAND_WIDTH(W)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .first_num(first_num), .first_den(first_den),
		.second_num(second_num), .second_den(second_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_num(result_num), .result_den(result_den),
		.less_flag(less_flag), .error_flag(error_flag)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned gcd_u(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic frac_result_t predict_fraction(logic op, logic signed [W-1:0] n1,
			logic signed [W-1:0] d1, logic signed [W-1:0] n2, logic signed [W-1:0] d2);
		frac_result_t r;
		longint p1, p2, dd, s;
		longint unsigned nm, dm, g;
		logic [63:0] nfull, dfull;
		p1 = longint'(n1) * longint'(d2);
		p2 = longint'(n2) * longint'(d1);
		r.num = '0;
		r.den = '0;
		r.less = 1'b0;
		r.err = 1'b0;
		if (op == OP_LT) begin
			r.less = (p1 < p2);
			return r;
		end
		dd = longint'(d1) * longint'(d2);
		s = p1 + p2;
		nm = (s < 0) ? longint'(-s) : s;
		dm = (dd < 0) ? longint'(-dd) : dd;
		r.err = (dm == 0);
		if (!r.err && nm != 0) begin
			g = gcd_u(nm, dm);
			nm = nm / g;
			dm = dm / g;
		end
		nfull = (s < 0) ? -nm : nm;
		dfull = (dd < 0) ? -dm : dm;
		r.num = nfull[32:0];
		r.den = dfull[31:0];
		return r;
	endfunction

	task automatic send_item(logic op, logic signed [W-1:0] n1, logic signed [W-1:0] d1,
			logic signed [W-1:0] n2, logic signed [W-1:0] d2);
		int gap;
		if (sender_idle_en) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 6);
				gap = $urandom_range(1, 12);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		pending_results.push_back(predict_fraction(op, n1, d1, n2, d2));
		in_valid   <= 1'b1;
		opcode     <= op;
		first_num  <= n1;
		first_den  <= d1;
		second_num <= n2;
		second_den <= d2;
		// hold the payload until the transfer
		do @(posedge clk); while (in_stall);
		sent_cnt++;
	endtask

	task automatic send_idle_end();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_field();
		case ($urandom_range(0, 5))
			0: return W'($urandom_range(0, 15)) - 16'sd7;
			1: return (($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000);
			2: return W'($urandom_range(0, 255)) - 16'sd128;
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic signed [W-1:0] mn_val();
		return 16'sh8000;
	endfunction

	task automatic test_extremes();
		logic signed [W-1:0] mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		send_item(OP_ADD, mx, mx, mx, mx);
		send_item(OP_ADD, mn, mn, mn, mn);
		send_item(OP_ADD, mn, mx, mx, mn);
		send_item(OP_ADD, mx, mn, mn, mx);
		send_item(OP_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_item(OP_LT,  mx, mx, mn, mn);
		send_item(OP_LT,  mn, mx, mx, mx);
		send_item(OP_LT,  mn, mn, mn, mn);
		send_item(OP_LT,  16'sd1, -16'sd2, 16'sd1, 16'sd2);
		send_item(OP_LT,  16'sd1, 16'sd3, 16'sd1, 16'sd2);
		send_item(OP_LT,  16'sd0, 16'sd0, 16'sd0, 16'sd0);
	endtask

	task automatic test_special_cases();
		// zero sum numerator, with and without a zero denominator
		send_item(OP_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
		send_item(OP_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7);
		send_item(OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd3);
		// zero sum denominator flags an error
		send_item(OP_ADD, 16'sd3, 16'sd0, 16'sd5, 16'sd9);
		send_item(OP_ADD, 16'sd4, 16'sd6, 16'sd2, 16'sd0);
		send_item(OP_ADD, mn_val(), 16'sd0, 16'sh7fff, 16'sd0);
		// a negative denominator with a zero sum stays negative; then reductions and a compare
		send_item(OP_ADD, 16'sd1, -16'sd4, 16'sd1, 16'sd4);
		send_item(OP_ADD, 16'sd2, -16'sd6, 16'sd4, 16'sd12);
		send_item(OP_ADD, 16'sd1024, 16'sd2048, 16'sd512, 16'sd4096);
		send_item(OP_ADD, 16'sd7, 16'sd13, 16'sd11, 16'sd17);
		send_item(OP_LT,  16'sd3, 16'sd0, 16'sd4, 16'sd0);
		send_item(OP_ADD, -16'sd9, 16'sd6, -16'sd15, 16'sd10);
	endtask

	task automatic test_random(int count);
		logic op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 2) == 0) ? OP_LT : OP_ADD;
			send_item(op, rand_field(), rand_field(), rand_field(), rand_field());
		end
	endtask

	task automatic test_backpressure();
		sender_idle_en = 0;
		hold_req = 1;
		test_random(40);
		sender_idle_en = 1;
	endtask

	// receiver stall pattern, with a long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_cnt == 0) hold_cnt = 600;
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
				if (hold_cnt == 0) hold_req = 0;
			end else if (rx_stall_free) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		frac_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			got_cnt++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d", $time, result_num,
					result_den);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.err) err_seen++;
				if (result_num !== e.num) begin
					$display("%0t: result_num expected %0d actual %0d", $time, e.num,
						result_num);
					errors++;
				end
				if (result_den !== e.den) begin
					$display("%0t: result_den expected %0d actual %0d", $time, e.den,
						result_den);
					errors++;
				end
				if (less_flag !== e.less) begin
					$display("%0t: less_flag expected %0b actual %0b", $time, e.less,
						less_flag);
					errors++;
				end
				if (error_flag !== e.err) begin
					$display("%0t: error_flag expected %0b actual %0b", $time, e.err,
						error_flag);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("FAIL rational_add_compare_unit");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_ADD;
		first_num  = '0;
		first_den  = '0;
		second_num = '0;
		second_den = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_cases();
		rx_stall_free = 1;
		test_random(300);
		rx_stall_free = 0;
		stall_pct = 70;
		test_random(300);
		stall_pct = 30;
		test_backpressure();
		test_random(860);
		send_idle_end();

		$display("Sent %0d fraction pairs, checked %0d results, %0d with zero denominator.",
			sent_cnt, got_cnt, err_seen);
		$display("Covered add and compare corners, random stalls and a long output hold.");
		if (errors == 0) begin
			$display("PASS rational_add_compare_unit");
		end else begin
			$display("FAIL rational_add_compare_unit");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/rac_pkg.sv
rtl/core/rational_add_compare_unit.sv
dv/tb_top.sv
